/* src/dss_pkg.sv */
// Shared types, constants and helpers for the 3x3 DEM slope pipeline.
`timescale 1ns / 1ps

package dss_pkg;

    localparam int ELEV_WIDTH_DEF = 24;
    localparam int CS_WIDTH       = 24;
    localparam int CFG_DATA_WIDTH = 32;
    localparam int SLOPE_WIDTH    = 32;
    localparam int K_WIDTH        = 16;
    localparam int DIV_WIDTH      = CS_WIDTH + K_WIDTH;
    localparam int SQRT2_Q13      = 11585;
    localparam int Q13_SHIFT      = 13;

    // Configuration register indexes
    localparam logic [1:0] CFG_ALGORITHM = 2'd0;
    localparam logic [1:0] CFG_CELL_SIZE = 2'd1;
    localparam logic [1:0] CFG_NODATA    = 2'd2;

    localparam logic [CS_WIDTH-1:0] CELL_SIZE_RESET = CS_WIDTH'(16);

    typedef enum logic [2:0] {
        ALG_FD   = 3'd0,
        ALG_FFD  = 3'd1,
        ALG_MD   = 3'd2,
        ALG_SD   = 3'd3,
        ALG_SFD  = 3'd4,
        ALG_TFD  = 3'd5,
        ALG_TFDW = 3'd6
    } alg_t;

    // Control that travels with each pipeline slot
    typedef struct packed {
        logic valid;
        logic nodata;
        logic md;
    } tag_t;

    // Divisor scale for each gradient method
    function automatic logic [K_WIDTH-1:0] div_k(input logic [2:0] alg);
        logic [K_WIDTH-1:0] k;
        unique case (alg_t'(alg))
            ALG_FFD:  k = K_WIDTH'(4);
            ALG_MD:   k = K_WIDTH'(1);
            ALG_SD:   k = K_WIDTH'(1);
            ALG_SFD:  k = K_WIDTH'(2);
            ALG_TFD:  k = K_WIDTH'(6);
            ALG_TFDW: k = K_WIDTH'(4 * (1 << Q13_SHIFT) + 2 * SQRT2_Q13);
            default:  k = K_WIDTH'(8);
        endcase
        return k;
    endfunction

endpackage

/* src/dss_grad.sv */
// Gradient stages: differences, method select, combine and magnitude.
`timescale 1ns / 1ps

module dss_grad #(
    parameter int ELEV_WIDTH = dss_pkg::ELEV_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic [2:0]                      alg,
    input  dss_pkg::tag_t                   tag_in,
    input  logic [8:0][ELEV_WIDTH-1:0]      elev,
    output dss_pkg::tag_t                   tag_out,
    output logic [ELEV_WIDTH+14:0]          mag_x,
    output logic [ELEV_WIDTH+14:0]          mag_y
);

    localparam int W  = ELEV_WIDTH;
    localparam int DW = W + 2;
    localparam int GW = W + 16;
    localparam int MW = W + 15;
    localparam logic signed [GW-1:0] SQ2 = GW'(dss_pkg::SQRT2_Q13);

    logic signed [DW-1:0] ex [9];

    logic signed [DW-1:0] p_next, q_next, r_next, t_next, u_next, v_next;
    logic signed [DW-1:0] p_reg, q_reg, r_reg, t_reg, u_reg, v_reg;
    logic signed [DW-1:0] dro_next [4];
    logic signed [DW-1:0] drd_next [4];
    logic signed [DW-1:0] dro_reg [4];
    logic signed [DW-1:0] drd_reg [4];

    logic signed [GW-1:0] bx_next, mx_next, by_next, my_next;
    logic signed [GW-1:0] bx_reg, mx_reg, by_reg, my_reg;
    logic [W-1:0]         mo_next, md_next, mo_reg, md_reg;

    logic signed [GW-1:0] gx_next, gy_next, gx_reg, gy_reg;
    logic [MW-1:0]        mag_x_next, mag_y_next, mag_x_reg, mag_y_reg;

    dss_pkg::tag_t tag_s2_reg, tag_s3_reg, tag_s4_reg, tag_s5_reg;

    // Sign-extend the window samples
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            ex[i] = DW'($signed(elev[i]));
        end
    end

    // Stage 2: basic differences and center drops
    always_comb
    begin
        p_next = ex[2] + ex[8] - ex[0] - ex[6];
        r_next = ex[0] + ex[2] - ex[6] - ex[8];
        q_next = ex[5] - ex[3];
        t_next = ex[1] - ex[7];
        u_next = ex[4] - ex[3];
        v_next = ex[4] - ex[7];
        for (int i = 0; i < 4; i++)
        begin
            dro_next[i] = ex[4] - ex[2 * i + 1];
            drd_next[i] = ex[4] - ex[(i < 2) ? 2 * i : 2 * i + 2];
        end
    end

    // Stage 3: pick gradient terms for the method
    always_comb
    begin
        bx_next = '0;
        mx_next = '0;
        by_next = '0;
        my_next = '0;
        unique case (dss_pkg::alg_t'(alg))
            dss_pkg::ALG_FFD:
            begin
                bx_next = GW'(p_reg);
                by_next = GW'(r_reg);
            end
            dss_pkg::ALG_MD:
            begin
                bx_next = '0;
                by_next = '0;
            end
            dss_pkg::ALG_SD:
            begin
                bx_next = GW'(u_reg);
                by_next = GW'(v_reg);
            end
            dss_pkg::ALG_SFD:
            begin
                bx_next = GW'(q_reg);
                by_next = GW'(t_reg);
            end
            dss_pkg::ALG_TFD:
            begin
                bx_next = GW'(p_reg) + GW'(q_reg);
                by_next = GW'(r_reg) + GW'(t_reg);
            end
            dss_pkg::ALG_TFDW:
            begin
                bx_next = GW'(p_reg) <<< dss_pkg::Q13_SHIFT;
                by_next = GW'(r_reg) <<< dss_pkg::Q13_SHIFT;
                mx_next = GW'(q_reg) * SQ2;
                my_next = GW'(t_reg) * SQ2;
            end
            default:
            begin
                bx_next = GW'(p_reg) + (GW'(q_reg) <<< 1);
                by_next = GW'(r_reg) + (GW'(t_reg) <<< 1);
            end
        endcase
    end

    // Stage 3: largest positive drop, orthogonal and diagonal
    always_comb
    begin
        mo_next = '0;
        md_next = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (dro_reg[i] > 0 && W'(dro_reg[i]) > mo_next)
            begin
                mo_next = W'(dro_reg[i]);
            end
            if (drd_reg[i] > 0 && W'(drd_reg[i]) > md_next)
            begin
                md_next = W'(drd_reg[i]);
            end
        end
    end

    // Stage 4: combine terms
    always_comb
    begin
        if (tag_s3_reg.md)
        begin
            gx_next = GW'(mo_reg);
            gy_next = GW'(md_reg);
        end
        else
        begin
            gx_next = bx_reg + mx_reg;
            gy_next = by_reg + my_reg;
        end
    end

    // Stage 5: magnitudes
    always_comb
    begin
        mag_x_next = gx_reg[GW-1] ? MW'(-gx_reg) : MW'(gx_reg);
        mag_y_next = gy_reg[GW-1] ? MW'(-gy_reg) : MW'(gy_reg);
    end

    // Advance slot control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_s2_reg <= '0;
            tag_s3_reg <= '0;
            tag_s4_reg <= '0;
            tag_s5_reg <= '0;
        end
        else if (en)
        begin
            tag_s2_reg <= tag_in;
            tag_s3_reg <= tag_s2_reg;
            tag_s4_reg <= tag_s3_reg;
            tag_s5_reg <= tag_s4_reg;
        end
    end

    // Advance data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg     <= p_next;
            q_reg     <= q_next;
            r_reg     <= r_next;
            t_reg     <= t_next;
            u_reg     <= u_next;
            v_reg     <= v_next;
            dro_reg   <= dro_next;
            drd_reg   <= drd_next;
            bx_reg    <= bx_next;
            mx_reg    <= mx_next;
            by_reg    <= by_next;
            my_reg    <= my_next;
            mo_reg    <= mo_next;
            md_reg    <= md_next;
            gx_reg    <= gx_next;
            gy_reg    <= gy_next;
            mag_x_reg <= mag_x_next;
            mag_y_reg <= mag_y_next;
        end
    end

    assign tag_out = tag_s5_reg;
    assign mag_x   = mag_x_reg;
    assign mag_y   = mag_y_reg;

endmodule

/* src/dss_sqsum.sv */
// Split squares and sum of squares (or max drop term) ahead of the root.
`timescale 1ns / 1ps

module dss_sqsum #(
    parameter int MW = dss_pkg::ELEV_WIDTH_DEF + 15
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  dss_pkg::tag_t    tag_in,
    input  logic [MW-1:0]    mag_x,
    input  logic [MW-1:0]    mag_y,
    output dss_pkg::tag_t    tag_out,
    output logic [2*MW+1:0]  sum_out
);

    localparam int H  = (MW + 1) / 2;
    localparam int HI = MW - H;
    localparam int SW = 2 * MW;
    localparam int XW = 2 * MW + 2;

    logic [2*HI-1:0] xhh_next, yhh_next, xhh_reg, yhh_reg;
    logic [MW-1:0]   xhl_next, yhl_next, xhl_reg, yhl_reg;
    logic [2*H-1:0]  xll_next, yll_next, xll_reg, yll_reg;
    logic [SW-1:0]   sqx_next, sqy_next, sqx_reg, sqy_reg;
    logic [XW-1:0]   ax, ay;
    logic [XW-1:0]   sum_next, sum_reg;

    dss_pkg::tag_t tag_s6_reg, tag_s7_reg, tag_s8_reg;

    // Stage 6: partial products of each square
    always_comb
    begin
        xhh_next = mag_x[MW-1:H] * mag_x[MW-1:H];
        xhl_next = mag_x[MW-1:H] * mag_x[H-1:0];
        xll_next = mag_x[H-1:0] * mag_x[H-1:0];
        yhh_next = mag_y[MW-1:H] * mag_y[MW-1:H];
        yhl_next = mag_y[MW-1:H] * mag_y[H-1:0];
        yll_next = mag_y[H-1:0] * mag_y[H-1:0];
    end

    // Stage 7: assemble squares
    always_comb
    begin
        sqx_next = (SW'(xhh_reg) << (2 * H)) + (SW'(xhl_reg) << (H + 1)) + SW'(xll_reg);
        sqy_next = (SW'(yhh_reg) << (2 * H)) + (SW'(yhl_reg) << (H + 1)) + SW'(yll_reg);
    end

    // Stage 8: doubled sum, or the larger drop term for max downslope
    always_comb
    begin
        ax = XW'(sqx_reg);
        ay = XW'(sqy_reg);
        if (tag_s7_reg.md)
        begin
            sum_next = ((ax << 1) > ay) ? (ax << 1) : ay;
        end
        else
        begin
            sum_next = (ax + ay) << 1;
        end
    end

    // Advance slot control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_s6_reg <= '0;
            tag_s7_reg <= '0;
            tag_s8_reg <= '0;
        end
        else if (en)
        begin
            tag_s6_reg <= tag_in;
            tag_s7_reg <= tag_s6_reg;
            tag_s8_reg <= tag_s7_reg;
        end
    end

    // Advance data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xhh_reg <= xhh_next;
            xhl_reg <= xhl_next;
            xll_reg <= xll_next;
            yhh_reg <= yhh_next;
            yhl_reg <= yhl_next;
            yll_reg <= yll_next;
            sqx_reg <= sqx_next;
            sqy_reg <= sqy_next;
            sum_reg <= sum_next;
        end
    end

    assign tag_out = tag_s8_reg;
    assign sum_out = sum_reg;

endmodule

/* src/dss_sqrt.sv */
// Pipelined integer square root of sum * 2^31, one root bit per stage.
`timescale 1ns / 1ps

module dss_sqrt #(
    parameter int XW = 2 * dss_pkg::ELEV_WIDTH_DEF + 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  dss_pkg::tag_t          tag_in,
    input  logic [XW-1:0]          sum_in,
    output dss_pkg::tag_t          tag_out,
    output logic [(XW+32)/2-1:0]   root_out
);

    localparam int RW  = (XW + 32) / 2;
    localparam int RDW = 2 * RW;

    logic [RDW-1:0] rad_reg  [RW];
    logic [RW:0]    rem_reg  [RW];
    logic [RW-1:0]  root_reg [RW];
    dss_pkg::tag_t  tag_reg  [RW];

    for (genvar k = 0; k < RW; k++)
    begin : g_stage
        logic [RDW-1:0] rad_src;
        logic [RW:0]    rem_src;
        logic [RW-1:0]  root_src;
        dss_pkg::tag_t  tag_src;
        logic [RW+2:0]  cur;
        logic [RW+2:0]  trial;
        logic           ge;
        logic [RDW-1:0] rad_next;
        logic [RW:0]    rem_next;
        logic [RW-1:0]  root_next;

        if (k == 0)
        begin : g_first
            assign rad_src  = {1'b0, sum_in, 31'b0};
            assign rem_src  = '0;
            assign root_src = '0;
            assign tag_src  = tag_in;
        end
        else
        begin : g_rest
            assign rad_src  = rad_reg[k-1];
            assign rem_src  = rem_reg[k-1];
            assign root_src = root_reg[k-1];
            assign tag_src  = tag_reg[k-1];
        end

        // Bring in two radicand bits and try the next root bit
        always_comb
        begin
            cur       = {rem_src, rad_src[RDW-1:RDW-2]};
            trial     = (RW + 3)'({root_src, 2'b01});
            ge        = (cur >= trial);
            rad_next  = rad_src << 2;
            rem_next  = ge ? (RW + 1)'(cur - trial) : (RW + 1)'(cur);
            root_next = {root_src[RW-2:0], ge};
        end

        // Advance slot control
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[k] <= '0;
            end
            else if (en)
            begin
                tag_reg[k] <= tag_src;
            end
        end

        // Advance data
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k]  <= rad_next;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
            end
        end
    end

    assign tag_out  = tag_reg[RW-1];
    assign root_out = root_reg[RW-1];

endmodule

/* src/dss_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module dss_div #(
    parameter int NW = dss_pkg::ELEV_WIDTH_DEF + 32,
    parameter int DW = dss_pkg::DIV_WIDTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  dss_pkg::tag_t    tag_in,
    input  logic [NW-1:0]    num_in,
    input  logic [DW-1:0]    divisor,
    output dss_pkg::tag_t    tag_out,
    output logic [NW-1:0]    quo_out
);

    logic [NW-1:0] num_reg [NW];
    logic [NW-1:0] quo_reg [NW];
    logic [DW-1:0] rem_reg [NW];
    dss_pkg::tag_t tag_reg [NW];

    for (genvar k = 0; k < NW; k++)
    begin : g_stage
        logic [NW-1:0] num_src;
        logic [NW-1:0] quo_src;
        logic [DW-1:0] rem_src;
        dss_pkg::tag_t tag_src;
        logic [DW:0]   cur;
        logic          ge;
        logic [DW-1:0] rem_next;

        if (k == 0)
        begin : g_first
            assign num_src = num_in;
            assign quo_src = '0;
            assign rem_src = '0;
            assign tag_src = tag_in;
        end
        else
        begin : g_rest
            assign num_src = num_reg[k-1];
            assign quo_src = quo_reg[k-1];
            assign rem_src = rem_reg[k-1];
            assign tag_src = tag_reg[k-1];
        end

        // Shift in the next dividend bit and subtract when it fits
        always_comb
        begin
            cur      = {rem_src, num_src[NW-1]};
            ge       = (cur >= {1'b0, divisor});
            rem_next = ge ? DW'(cur - {1'b0, divisor}) : DW'(cur);
        end

        // Advance slot control
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[k] <= '0;
            end
            else if (en)
            begin
                tag_reg[k] <= tag_src;
            end
        end

        // Advance data
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[k] <= num_src << 1;
                quo_reg[k] <= {quo_src[NW-2:0], ge};
                rem_reg[k] <= rem_next;
            end
        end
    end

    assign tag_out = tag_reg[NW-1];
    assign quo_out = quo_reg[NW-1];

endmodule

/* src/dem_slope_3x3_top.sv */
// Throughput: one window per cycle unless m_axis holds an untaken result; the root
// and divider pipelines each resolve one bit per stage, so their depth sets the
// latency, not the rate.
// Reset: clears all valid bits, algorithm to FD, cell size to 16 and the nodata code
// to 0x800000 truncated to ELEV_WIDTH. No clearing pass; ready right after reset.
`timescale 1ns / 1ps

module dem_slope_3x3_top #(
    parameter int ELEV_WIDTH = dss_pkg::ELEV_WIDTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // tdata: elev_nw, elev_n, elev_ne, elev_w, elev_center, elev_e, elev_sw, elev_s,
    //        elev_se, ELEV_WIDTH bits each from bit 0 up, zero fill to whole bytes
    input  logic [((9*ELEV_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tdata: slope_value (32 bits)
    output logic [dss_pkg::SLOPE_WIDTH-1:0]         m_axis_tdata,
    // tuser: is_nodata
    output logic [0:0]                              m_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [1:0]                              cfg_addr,
    input  logic [dss_pkg::CFG_DATA_WIDTH-1:0]      cfg_data
);

    localparam int W  = ELEV_WIDTH;
    localparam int MW = W + 15;
    localparam int XW = 2 * MW + 2;
    localparam int RW = (XW + 32) / 2;
    localparam int DV = dss_pkg::DIV_WIDTH;
    localparam int SL = dss_pkg::SLOPE_WIDTH;
    localparam int CS = dss_pkg::CS_WIDTH;

    logic [2:0]    alg_reg;
    logic [CS-1:0] cs_reg;
    logic [W-1:0]  nodata_reg;
    logic [DV-1:0] div_reg;
    logic [DV-1:0] div_next;
    logic [CS-1:0] cs_eff;

    logic                 adv;
    logic [8:0][W-1:0]    win;
    logic                 missing;
    dss_pkg::tag_t        tag_in_next;
    dss_pkg::tag_t        tag_s1_reg;
    logic [8:0][W-1:0]    elev_reg;

    dss_pkg::tag_t   tag_grad, tag_sum, tag_root, tag_quo;
    logic [MW-1:0]   mag_x, mag_y;
    logic [XW-1:0]   sum_w;
    logic [RW-1:0]   root_w;
    logic [RW-1:0]   quo_w;

    logic          out_valid_reg;
    logic [SL-1:0] out_slope_reg;
    logic          out_nodata_reg;
    logic [SL-1:0] slope_next;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alg_reg    <= dss_pkg::ALG_FD;
            cs_reg     <= dss_pkg::CELL_SIZE_RESET;
            nodata_reg <= W'(24'h800000);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_addr)
                dss_pkg::CFG_ALGORITHM: alg_reg    <= cfg_data[2:0];
                dss_pkg::CFG_CELL_SIZE: cs_reg     <= cfg_data[CS-1:0];
                dss_pkg::CFG_NODATA:    nodata_reg <= cfg_data[W-1:0];
                default:                ;
            endcase
        end
    end

    // Divisor K * cell_size, zero cell size taken as one
    always_comb
    begin
        cs_eff   = (cs_reg == '0) ? CS'(1) : cs_reg;
        div_next = DV'(dss_pkg::div_k(alg_reg)) * DV'(cs_eff);
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
    end

    // Whole pipeline moves unless the output holds an untaken result
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // Unpack window and check for missing samples
    always_comb
    begin
        missing = 1'b0;
        for (int i = 0; i < 9; i++)
        begin
            win[i] = s_axis_tdata[i*W +: W];
            if (win[i] == nodata_reg)
            begin
                missing = 1'b1;
            end
        end
        tag_in_next.valid  = s_axis_tvalid;
        tag_in_next.nodata = missing;
        tag_in_next.md     = (alg_reg == dss_pkg::ALG_MD);
    end

    // Stage 1: input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_s1_reg <= '0;
        end
        else if (adv)
        begin
            tag_s1_reg <= tag_in_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            elev_reg <= win;
        end
    end

    dss_grad #(
        .ELEV_WIDTH (W)
    ) u_grad (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .alg     (alg_reg),
        .tag_in  (tag_s1_reg),
        .elev    (elev_reg),
        .tag_out (tag_grad),
        .mag_x   (mag_x),
        .mag_y   (mag_y)
    );

    dss_sqsum #(
        .MW (MW)
    ) u_sqsum (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .tag_in  (tag_grad),
        .mag_x   (mag_x),
        .mag_y   (mag_y),
        .tag_out (tag_sum),
        .sum_out (sum_w)
    );

    dss_sqrt #(
        .XW (XW)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .tag_in   (tag_sum),
        .sum_in   (sum_w),
        .tag_out  (tag_root),
        .root_out (root_w)
    );

    dss_div #(
        .NW (RW),
        .DW (DV)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .tag_in  (tag_root),
        .num_in  (root_w),
        .divisor (div_reg),
        .tag_out (tag_quo),
        .quo_out (quo_w)
    );

    // Saturate to 32 bits; nodata windows report zero
    always_comb
    begin
        if (tag_quo.nodata)
        begin
            slope_next = '0;
        end
        else if (|quo_w[RW-1:SL])
        begin
            slope_next = '1;
        end
        else
        begin
            slope_next = quo_w[SL-1:0];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= tag_quo.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_slope_reg  <= slope_next;
            out_nodata_reg <= tag_quo.nodata;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_slope_reg;
    assign m_axis_tuser[0] = out_nodata_reg;

endmodule
